@@ sv/text_console_character_writer_top_defines.svh @@
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define TCW_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/tcw_pkg.sv @@
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [ROW_W:0]    row_ext_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [4:0]        in_row_t;
  typedef logic [6:0]        in_col_t;
  typedef logic [4:0]        out_row_t;
  typedef logic [6:0]        out_col_t;

  typedef enum logic [2:0] {
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_PRINT,
    CMD_READ,
    CMD_READ_NONE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] ch;
    logic [7:0] attr;
    row_t       row;
    col_t       col;
  } cmd_t;

endpackage

@@ sv/text_console_character_writer_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit first)                         tuser
// s_axis    in         char_code, attribute, read_row, read_col      opcode (tlast: end_of_text)
// m_axis    out        cell_char, cell_attr, cursor_row_out,          none
//                      cursor_col_out
//
// A read beat passes through ST_READ for the registered cell memory read before its
// result reaches the output register. A put that scrolls then clears the bottom row
// in ST_CLEAR, since the rows themselves are moved by a ring offset. After reset a
// clearing pass over all ROWS * COLUMNS cells (2000) runs with s_axis_tready_o low.
// A two-beat queue between the front and back ends and the output register let
// each side stall on its own.

module text_console_character_writer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // char_code, attribute, read_row, read_col
  input  logic        s_axis_tuser_i,   // opcode
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // cell_char, cell_attr, cursor_row_out, cursor_col_out
);

  logic          busy;
  logic          cmd_valid;
  logic          cmd_ready;
  tcw_pkg::cmd_t cmd;

  tcw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .busy_i          (busy),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd)
  );

  tcw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .busy_o          (busy),
    .cmd_valid_i     (cmd_valid),
    .cmd_ready_o     (cmd_ready),
    .cmd_i           (cmd),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

@@ sv/tcw_front.sv @@
`timescale 1ns / 1ps

module tcw_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          busy_i,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [31:0]   s_axis_tdata_i,
  input  logic          s_axis_tuser_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output tcw_pkg::cmd_t cmd_o
);

  tcw_pkg::cmd_t    q_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;
  tcw_pkg::cmd_t    cls;
  logic             push;
  logic             pop;
  logic [7:0]       in_ch;
  logic [7:0]       in_attr;
  tcw_pkg::in_row_t in_row;
  tcw_pkg::in_col_t in_col;
  logic             in_range;

  assign in_ch    = s_axis_tdata_i[7:0];
  assign in_attr  = s_axis_tdata_i[15:8];
  assign in_row   = s_axis_tdata_i[20:16];
  assign in_col   = s_axis_tdata_i[27:21];
  assign in_range = (int'(in_row) < tcw_pkg::ROWS) && (int'(in_col) < tcw_pkg::COLUMNS);

  always_comb begin
    cls.ch   = in_ch;
    cls.attr = in_attr;
    cls.row  = tcw_pkg::row_t'(in_row);
    cls.col  = tcw_pkg::col_t'(in_col);
    if (s_axis_tuser_i == tcw_pkg::OP_READ) begin
      cls.kind = in_range ? tcw_pkg::CMD_READ : tcw_pkg::CMD_READ_NONE;
    end else if (in_ch == tcw_pkg::CH_NEWLINE) begin
      cls.kind = tcw_pkg::CMD_NEWLINE;
    end else if (in_ch == tcw_pkg::CH_BACKSPACE) begin
      cls.kind = tcw_pkg::CMD_BACKSPACE;
    end else begin
      cls.kind = tcw_pkg::CMD_PRINT;
    end
  end

  assign s_axis_tready_o = (cnt_q != 2'd2) && !busy_i;
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd_valid_o     = (cnt_q != 2'd0);
  assign pop             = cmd_valid_o && cmd_ready_i;
  assign cmd_o           = q_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ sv/tcw_back.sv @@
`timescale 1ns / 1ps

module tcw_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          busy_o,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  tcw_pkg::cmd_t cmd_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [31:0]   m_axis_tdata_o
);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR
  } state_e;

  state_e             state_q;
  tcw_pkg::row_t      row_q;
  tcw_pkg::col_t      col_q;
  tcw_pkg::row_t      base_q;
  tcw_pkg::addr_t     clr_q;
  tcw_pkg::addr_t     clr_base_q;
  logic               out_valid_q;
  logic [7:0]         out_char_q;
  logic [7:0]         out_attr_q;
  tcw_pkg::out_row_t  out_row_q;
  tcw_pkg::out_col_t  out_col_q;

  logic [15:0]        mem [tcw_pkg::CELL_COUNT];
  logic [15:0]        rd_data_q;
  tcw_pkg::addr_t     rd_addr;
  logic               we;
  tcw_pkg::addr_t     waddr;
  logic [15:0]        wdata;

  logic               slot_free;
  logic               take;
  tcw_pkg::row_ext_t  row_nx;
  tcw_pkg::col_t      col_nx;
  tcw_pkg::row_t      row_fin;
  tcw_pkg::row_t      base_nx;
  logic               scroll;
  logic               put_we;
  tcw_pkg::row_t      put_wrow;
  tcw_pkg::col_t      put_wcol;
  logic [15:0]        put_wdata;

  // Rows live in the store as a ring; base_q is the physical row of screen row 0.
  function automatic tcw_pkg::addr_t map_addr(tcw_pkg::row_t r, tcw_pkg::col_t c,
                                              tcw_pkg::row_t b);
    tcw_pkg::row_ext_t s;
    tcw_pkg::row_t     p;
    s = {1'b0, r} + {1'b0, b};
    if (int'(s) >= tcw_pkg::ROWS) begin
      s = s - tcw_pkg::row_ext_t'(tcw_pkg::ROWS);
    end
    p = tcw_pkg::row_t'(s);
    return tcw_pkg::addr_t'(int'(p) * tcw_pkg::COLUMNS + int'(c));
  endfunction

  assign slot_free   = !out_valid_q || m_axis_tready_i;
  assign cmd_ready_o = (state_q == ST_IDLE) && slot_free;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign busy_o      = (state_q == ST_INIT);

  always_comb begin
    row_nx    = {1'b0, row_q};
    col_nx    = col_q;
    put_we    = 1'b0;
    put_wrow  = row_q;
    put_wcol  = col_q;
    put_wdata = 16'h0000;
    case (cmd_i.kind)
      tcw_pkg::CMD_NEWLINE: begin
        col_nx = '0;
        row_nx = {1'b0, row_q} + 1'b1;
      end
      tcw_pkg::CMD_BACKSPACE: begin
        if (row_q != '0 || col_q != '0) begin
          put_we = 1'b1;
          if (col_q == '0) begin
            row_nx = {1'b0, row_q} - 1'b1;
            col_nx = tcw_pkg::col_t'(tcw_pkg::COLUMNS - 1);
          end else begin
            col_nx = col_q - 1'b1;
          end
          put_wrow = tcw_pkg::row_t'(row_nx);
          put_wcol = col_nx;
        end
      end
      tcw_pkg::CMD_PRINT: begin
        put_we    = 1'b1;
        put_wdata = {cmd_i.attr, cmd_i.ch};
        if (col_q == tcw_pkg::col_t'(tcw_pkg::COLUMNS - 1)) begin
          col_nx = '0;
          row_nx = {1'b0, row_q} + 1'b1;
        end else begin
          col_nx = col_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
    scroll  = (row_nx == tcw_pkg::row_ext_t'(tcw_pkg::ROWS));
    row_fin = scroll ? tcw_pkg::row_t'(tcw_pkg::ROWS - 1) : tcw_pkg::row_t'(row_nx);
    base_nx = (base_q == tcw_pkg::row_t'(tcw_pkg::ROWS - 1)) ? '0 : base_q + 1'b1;
  end

  always_comb begin
    rd_addr = map_addr(cmd_i.row, cmd_i.col, base_q);
    we      = 1'b0;
    waddr   = clr_q;
    wdata   = 16'h0000;
    case (state_q)
      ST_INIT: begin
        we = 1'b1;
      end
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_base_q + clr_q;
      end
      ST_IDLE: begin
        we    = take && put_we;
        waddr = map_addr(put_wrow, put_wcol, base_q);
        wdata = put_wdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= '0;
      col_q       <= '0;
      base_q      <= '0;
      clr_q       <= '0;
      clr_base_q  <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_attr_q  <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == tcw_pkg::addr_t'(tcw_pkg::CELL_COUNT - 1)) begin
            clr_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (take) begin
            case (cmd_i.kind)
              tcw_pkg::CMD_READ: begin
                state_q <= ST_READ;
              end
              tcw_pkg::CMD_READ_NONE: begin
                out_valid_q <= 1'b1;
                out_char_q  <= '0;
                out_attr_q  <= '0;
                out_row_q   <= tcw_pkg::out_row_t'(row_q);
                out_col_q   <= tcw_pkg::out_col_t'(col_q);
              end
              default: begin
                row_q <= row_fin;
                col_q <= col_nx;
                if (scroll) begin
                  base_q     <= base_nx;
                  clr_base_q <= tcw_pkg::addr_t'(int'(base_q) * tcw_pkg::COLUMNS);
                  clr_q      <= '0;
                  state_q    <= ST_CLEAR;
                end else begin
                  out_valid_q <= 1'b1;
                  out_char_q  <= '0;
                  out_attr_q  <= '0;
                  out_row_q   <= tcw_pkg::out_row_t'(row_fin);
                  out_col_q   <= tcw_pkg::out_col_t'(col_nx);
                end
              end
            endcase
          end
        end
        ST_READ: begin
          out_valid_q <= 1'b1;
          out_char_q  <= rd_data_q[7:0];
          out_attr_q  <= rd_data_q[15:8];
          out_row_q   <= tcw_pkg::out_row_t'(row_q);
          out_col_q   <= tcw_pkg::out_col_t'(col_q);
          state_q     <= ST_IDLE;
        end
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == tcw_pkg::addr_t'(tcw_pkg::COLUMNS - 1)) begin
            clr_q       <= '0;
            out_valid_q <= 1'b1;
            out_char_q  <= '0;
            out_attr_q  <= '0;
            out_row_q   <= tcw_pkg::out_row_t'(row_q);
            out_col_q   <= tcw_pkg::out_col_t'(col_q);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_col_q, out_row_q, out_attr_q, out_char_q};

endmodule

@@ sv/tcw_checker.sv @@
`timescale 1ns / 1ps
`include "text_console_character_writer_top_defines.svh"

module tcw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [31:0] s_axis_tdata_i,
  input logic        s_axis_tuser_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  tcw_pkg::out_row_t out_row;
  tcw_pkg::out_col_t out_col;
  logic              out_wait;
  logic              in_wait;
  logic [33:0]       in_beat;
  logic              cursor_ok;

  assign out_row   = m_axis_tdata_o[20:16];
  assign out_col   = m_axis_tdata_o[27:21];
  assign out_wait  = m_axis_tvalid_o && !m_axis_tready_i;
  assign in_wait   = s_axis_tvalid_i && !s_axis_tready_o;
  assign in_beat   = {s_axis_tlast_i, s_axis_tuser_i, s_axis_tdata_i};
  assign cursor_ok = (int'(out_row) < tcw_pkg::ROWS) && (int'(out_col) < tcw_pkg::COLUMNS);

  `TCW_ASSERT_NEXT(a_out_hold, out_wait, m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `TCW_ASSERT_NEXT(a_in_hold, in_wait, s_axis_tvalid_i && $stable(in_beat))
  `TCW_ASSERT_IMPLY(a_cursor_range, m_axis_tvalid_o, cursor_ok)
  `TCW_ASSERT_IMPLY(a_pad_zero, m_axis_tvalid_o, m_axis_tdata_o[31:28] == 4'b0000)
  `TCW_ASSERT_IMPLY(a_clear_after_reset, !$past(rst_ni), !s_axis_tready_o && !m_axis_tvalid_o)

endmodule

bind text_console_character_writer_top tcw_checker u_tcw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic              opcode;
    logic [7:0]        ch;
    logic [7:0]        attr;
    tcw_pkg::in_row_t  rrow;
    tcw_pkg::in_col_t  rcol;
    logic              eot;
  } console_item_t;

  typedef struct {
    logic [7:0]        cell_char;
    logic [7:0]        cell_attr;
    tcw_pkg::out_row_t row;
    tcw_pkg::out_col_t col;
  } screen_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  console_item_t  console_items_q[$];
  screen_result_t expected_screen_q[$];
  console_item_t  beat_item;

  logic [15:0]       screen_cells[tcw_pkg::CELL_COUNT];
  tcw_pkg::out_row_t cur_row;
  tcw_pkg::out_col_t cur_col;

  int sent_count = 0;
  int recv_count = 0;
  int mismatch_count = 0;
  int put_count = 0;
  int read_count = 0;
  int scroll_count = 0;
  int wrap_count = 0;
  int back_wrap_count = 0;

  text_console_character_writer_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic screen_result_t console_apply(console_item_t it);
    screen_result_t res;
    logic [15:0]    cell_word;
    int             idx;
    res.cell_char = '0;
    res.cell_attr = '0;
    if (it.opcode == tcw_pkg::OP_PUT) begin
      put_count++;
      if (it.ch == tcw_pkg::CH_NEWLINE) begin
        cur_col = '0;
        cur_row++;
      end else if (it.ch == tcw_pkg::CH_BACKSPACE) begin
        if (cur_row != 0 || cur_col != 0) begin
          if (cur_col == 0) begin
            cur_row--;
            cur_col = tcw_pkg::out_col_t'(tcw_pkg::COLUMNS);
            back_wrap_count++;
          end
          cur_col--;
          screen_cells[int'(cur_row) * tcw_pkg::COLUMNS + int'(cur_col)] = '0;
        end
      end else begin
        screen_cells[int'(cur_row) * tcw_pkg::COLUMNS + int'(cur_col)] = {it.attr, it.ch};
        cur_col++;
        if (cur_col >= tcw_pkg::COLUMNS) begin
          cur_col = '0;
          cur_row++;
          wrap_count++;
        end
      end
      if (cur_row >= tcw_pkg::ROWS) begin
        for (idx = 0; idx < tcw_pkg::COLUMNS * (tcw_pkg::ROWS - 1); idx++) begin
          screen_cells[idx] = screen_cells[idx + tcw_pkg::COLUMNS];
        end
        for (idx = tcw_pkg::COLUMNS * (tcw_pkg::ROWS - 1); idx < tcw_pkg::CELL_COUNT;
             idx++) begin
          screen_cells[idx] = '0;
        end
        cur_row = tcw_pkg::out_row_t'(tcw_pkg::ROWS - 1);
        scroll_count++;
      end
    end else begin
      read_count++;
      if (it.rrow < tcw_pkg::ROWS && it.rcol < tcw_pkg::COLUMNS) begin
        cell_word = screen_cells[int'(it.rrow) * tcw_pkg::COLUMNS + int'(it.rcol)];
        res.cell_char = cell_word[7:0];
        res.cell_attr = cell_word[15:8];
      end
    end
    res.row = cur_row;
    res.col = cur_col;
    return res;
  endfunction

  task automatic push_item(logic op, logic [7:0] ch, logic [7:0] attr,
                           tcw_pkg::in_row_t rrow, tcw_pkg::in_col_t rcol, logic eot);
    console_item_t it;
    it.opcode = op;
    it.ch     = ch;
    it.attr   = attr;
    it.rrow   = rrow;
    it.rcol   = rcol;
    it.eot    = eot;
    console_items_q.push_back(it);
  endtask

  task automatic push_put(logic [7:0] ch, logic eot);
    push_item(tcw_pkg::OP_PUT, ch, 8'($urandom), 5'($urandom), 7'($urandom), eot);
  endtask

  task automatic push_read(tcw_pkg::in_row_t rrow, tcw_pkg::in_col_t rcol);
    push_item(tcw_pkg::OP_READ, 8'($urandom), 8'($urandom), rrow, rcol, 1'($urandom));
  endtask

  function automatic logic [7:0] pick_text_char();
    int p;
    p = $urandom_range(99);
    if (p < 12) return tcw_pkg::CH_NEWLINE;
    if (p < 22) return tcw_pkg::CH_BACKSPACE;
    return 8'($urandom_range(255));
  endfunction

  // Driver: a new beat may be offered only when the current one is taken or none is up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_screen_q.push_back(console_apply(beat_item));
        sent_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (console_items_q.size() != 0 &&
            ((sent_count >= 800 && sent_count < 1100) || $urandom_range(99) >= 31)) begin
          beat_item = console_items_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, beat_item.rcol, beat_item.rrow, beat_item.attr,
                            beat_item.ch};
          s_axis_tuser  <= beat_item.opcode;
          s_axis_tlast  <= beat_item.eot;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every output beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    screen_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        recv_count++;
        if (expected_screen_q.size() == 0) begin
          $display("%0t: beat expected none actual %h", $realtime, m_axis_tdata);
          mismatch_count++;
        end else begin
          want = expected_screen_q.pop_front();
          if (m_axis_tdata[7:0] != want.cell_char) begin
            $display("%0t: cell_char expected %h actual %h", $realtime,
                     want.cell_char, m_axis_tdata[7:0]);
            mismatch_count++;
          end
          if (m_axis_tdata[15:8] != want.cell_attr) begin
            $display("%0t: cell_attr expected %h actual %h", $realtime,
                     want.cell_attr, m_axis_tdata[15:8]);
            mismatch_count++;
          end
          if (m_axis_tdata[20:16] != want.row) begin
            $display("%0t: cursor_row expected %0d actual %0d", $realtime,
                     want.row, m_axis_tdata[20:16]);
            mismatch_count++;
          end
          if (m_axis_tdata[27:21] != want.col) begin
            $display("%0t: cursor_col expected %0d actual %0d", $realtime,
                     want.col, m_axis_tdata[27:21]);
            mismatch_count++;
          end
        end
      end
      m_axis_tready <= (recv_count >= 800 && recv_count < 1100) ||
                       ($urandom_range(99) >= 31);
    end
  end

  initial begin
    int kind;
    int len;
    int k;
    for (k = 0; k < tcw_pkg::CELL_COUNT; k++) begin
      screen_cells[k] = '0;
    end
    cur_row = '0;
    cur_col = '0;

    push_read(5'd0, 7'd0);
    push_read(5'd31, 7'd127);
    push_read(5'd24, 7'd79);
    push_read(5'd25, 7'd0);
    push_read(5'd0, 7'd80);
    push_put(tcw_pkg::CH_BACKSPACE, 1'b1);
    push_item(tcw_pkg::OP_PUT, 8'h00, 8'hFF, 5'd0, 7'd0, 1'b0);
    push_item(tcw_pkg::OP_PUT, 8'hFF, 8'h00, 5'd31, 7'd127, 1'b1);
    push_put(tcw_pkg::CH_NEWLINE, 1'b0);
    push_put(tcw_pkg::CH_BACKSPACE, 1'b0);
    push_item(tcw_pkg::OP_PUT, 8'h5A, 8'hA5, 5'd12, 7'd40, 1'b1);
    push_read(5'd0, 7'd79);
    push_read(5'd0, 7'd0);
    push_read(5'd0, 7'd1);
    push_put(tcw_pkg::CH_BACKSPACE, 1'b1);
    push_read(5'd0, 7'd79);
    push_item(tcw_pkg::OP_READ, tcw_pkg::CH_NEWLINE, 8'hFF, 5'd1, 7'd0, 1'b1);
    push_item(tcw_pkg::OP_READ, tcw_pkg::CH_BACKSPACE, 8'h00, 5'd0, 7'd0, 1'b0);

    while (console_items_q.size() < 2000) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 40);
        for (k = 0; k < len; k++) begin
          push_put(pick_text_char(), k == len - 1);
        end
      end else if (kind < 65) begin
        len = $urandom_range(1, 30);
        for (k = 0; k < len; k++) begin
          push_put(tcw_pkg::CH_NEWLINE, k == len - 1);
        end
      end else if (kind < 95) begin
        if ($urandom_range(99) < 15) begin
          push_read(5'($urandom), 7'($urandom));
        end else begin
          push_read(tcw_pkg::in_row_t'($urandom_range(tcw_pkg::ROWS - 1)),
                    tcw_pkg::in_col_t'($urandom_range(tcw_pkg::COLUMNS - 1)));
        end
      end else begin
        len = $urandom_range(1, 100);
        for (k = 0; k < len; k++) begin
          push_put(tcw_pkg::CH_BACKSPACE, k == len - 1);
        end
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (console_items_q.size() != 0 || s_axis_tvalid || expected_screen_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (200) @(posedge clk_i);

    $display("Checked %0d beats: %0d puts, %0d reads.", recv_count, put_count, read_count);
    $display("Saw %0d scrolls, %0d line wraps, %0d backspaces across a line start.",
             scroll_count, wrap_count, back_wrap_count);
    if (mismatch_count == 0 && expected_screen_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Timeout with %0d results outstanding.", expected_screen_q.size());
    $display("tb_top failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_front.sv
sv/tcw_back.sv
sv/text_console_character_writer_top.sv
sv/tcw_checker.sv
tb/tb_top.sv
